// ===== rtl/upc_pkg.sv =====
// Package for the update package checker: types, codes, constants and the CRC-32 byte step.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package upc_pkg;

   localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;
   localparam logic [31:0] TAG_WORD     = 32'h544F_4F42;
   localparam logic [31:0] MIN_PACKAGE  = 32'd28;
   localparam logic [33:0] BODY_PLUS_FOOTER = 34'd28;
   localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
   localparam logic [23:0] MAIN_LIMIT_RESET   = 24'd524288;
   localparam logic [23:0] SECOND_LIMIT_RESET = 24'd131072;

   localparam logic [31:0] NIB_TABLE [16] = '{
      32'h0000_0000, 32'h1DB7_1064, 32'h3B6E_20C8, 32'h26D9_30AC,
      32'h76DC_4190, 32'h6B6B_51F4, 32'h4DB2_6158, 32'h5005_713C,
      32'hEDB8_8320, 32'hF00F_9344, 32'hD6D6_A3E8, 32'hCB61_B38C,
      32'h9B64_C2B0, 32'h86D3_D2D4, 32'hA00A_E278, 32'hBDBD_F21C
   };

   typedef enum logic [2:0] {
      STATUS_OK            = 3'd0,
      STATUS_SIZE_MISMATCH = 3'd1,
      STATUS_CRC_MISMATCH  = 3'd2,
      STATUS_OUT_OF_RANGE  = 3'd3,
      STATUS_RAW_TOO_LARGE = 3'd4
   } status_type;

   typedef enum logic [0:0] {
      CSR_MAIN_LIMIT   = 1'b0,
      CSR_SECOND_LIMIT = 1'b1
   } csr_index_type;

   // Frame snapshot handed from the accumulator to the verdict stage
   typedef struct packed {
      logic [31:0] byte_count;
      logic [31:0] leading_word;
      logic [31:0] main_size;
      logic [31:0] second_size;
      logic [31:0] extra_size;
      logic [31:0] running_crc;
      logic [31:0] footer_word;
   } snap_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      c = (c >> 4) ^ NIB_TABLE[c[3:0]];
      c = (c >> 4) ^ NIB_TABLE[c[3:0]];
      return c;
   endfunction

endpackage

// ===== rtl/upc_if.sv =====
// Channel interfaces of the update package checker: byte requests and verdict responses.
// Depends on upc_pkg for nothing but shares its field widths.
`timescale 1ns / 1ps

interface upc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       final_byte;

   modport source(output valid, data_byte, final_byte, input ready);
   modport sink(input valid, data_byte, final_byte, output ready);
endinterface

interface upc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic        is_package;
   logic [1:0]  image_count;
   logic [23:0] main_length;
   logic [23:0] second_length;

   modport source(output valid, status, is_package, image_count, main_length,
                  second_length, input ready);
   modport sink(input valid, status, is_package, image_count, main_length,
                second_length, output ready);
endinterface

// ===== rtl/update_package_checker_top.sv =====
// Top level of the update package checker: channel interfaces, limit registers, two stages.
// Depends on upc_pkg, upc_if, upc_frame and upc_verdict.
`timescale 1ns / 1ps

// Takes one file byte per clock on the request channel, with no gaps needed between
// bytes or files, unless a held snapshot stalls the request channel; the CRC-32 step
// (two nibble lookups) and header capture are combinational, setting the one-byte-per-cycle rate.
// A byte marked final yields one response transaction: the file is snapshotted into the
// snapshot register, then the length, CRC and limit checks fill the result register. Other
// bytes yield nothing. The limit registers should be written only while no file is in flight.

module update_package_checker_top (
   input  logic        clock,
   input  logic        reset,
   upc_req_if.sink     req_if,
   upc_rsp_if.source   rsp_if,
   input  logic        csr_write_enable,
   input  logic [0:0]  csr_index,
   input  logic [23:0] csr_write_data
);

   logic [23:0]       main_limit_ff;
   logic [23:0]       second_limit_ff;
   logic              snap_valid;
   logic              snap_ready;
   upc_pkg::snap_type snap;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_limit_ff   <= upc_pkg::MAIN_LIMIT_RESET;
         second_limit_ff <= upc_pkg::SECOND_LIMIT_RESET;
      end else if (csr_write_enable) begin
         case (upc_pkg::csr_index_type'(csr_index))
            upc_pkg::CSR_MAIN_LIMIT:   main_limit_ff   <= csr_write_data;
            upc_pkg::CSR_SECOND_LIMIT: second_limit_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   upc_frame u_frame (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_if.valid),
      .in_ready   (req_if.ready),
      .data_byte  (req_if.data_byte),
      .final_byte (req_if.final_byte),
      .snap_valid (snap_valid),
      .snap_ready (snap_ready),
      .snap       (snap)
   );

   upc_verdict u_verdict (
      .clock         (clock),
      .reset         (reset),
      .snap_valid    (snap_valid),
      .snap_ready    (snap_ready),
      .snap          (snap),
      .main_limit    (main_limit_ff),
      .second_limit  (second_limit_ff),
      .out_valid     (rsp_if.valid),
      .out_ready     (rsp_if.ready),
      .status        (rsp_if.status),
      .is_package    (rsp_if.is_package),
      .image_count   (rsp_if.image_count),
      .main_length   (rsp_if.main_length),
      .second_length (rsp_if.second_length)
   );

endmodule

// ===== rtl/upc_frame.sv =====
// Per-file accumulator: byte counter, header fields, CRC-32 and footer delay line.
// Depends on upc_pkg; hands a snapshot of the finished file to upc_verdict.
`timescale 1ns / 1ps

module upc_frame (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [7:0]        data_byte,
   input  logic              final_byte,
   output logic              snap_valid,
   input  logic              snap_ready,
   output upc_pkg::snap_type snap
);

   logic [31:0] count_ff, count_in;
   logic [31:0] lead_ff, lead_in;
   logic [31:0] main_ff, main_in;
   logic [31:0] second_ff, second_in;
   logic [31:0] extra_ff, extra_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] footer_ff, footer_in;
   logic        snap_valid_ff, snap_valid_in;
   upc_pkg::snap_type snap_ff, snap_in;
   logic [31:0] byte_word;
   logic        accept;

   assign in_ready   = !snap_valid_ff || snap_ready;
   assign accept     = in_valid && in_ready;
   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

   always_comb begin
      byte_word = {24'd0, data_byte} << {count_ff[1:0], 3'b000};
      lead_in   = lead_ff;
      main_in   = main_ff;
      second_in = second_ff;
      extra_in  = extra_ff;
      if (count_ff < 32'd4) begin
         lead_in = lead_ff | byte_word;
      end else if (count_ff < 32'd8) begin
         main_in = main_ff | byte_word;
      end else if (count_ff < 32'd12) begin
         second_in = second_ff | byte_word;
      end else if (count_ff < 32'd16) begin
         extra_in = extra_ff | byte_word;
      end
      crc_in    = (count_ff >= 32'd4) ? upc_pkg::crc_byte(crc_ff, footer_ff[7:0]) : crc_ff;
      footer_in = {data_byte, footer_ff[31:8]};
      count_in  = (count_ff == upc_pkg::COUNT_MAX) ? count_ff : count_ff + 32'd1;

      snap_in.byte_count   = count_in;
      snap_in.leading_word = lead_in;
      snap_in.main_size    = main_in;
      snap_in.second_size  = second_in;
      snap_in.extra_size   = extra_in;
      snap_in.running_crc  = crc_in;
      snap_in.footer_word  = footer_in;

      if (accept && final_byte) begin
         snap_valid_in = 1'b1;
      end else if (snap_ready) begin
         snap_valid_in = 1'b0;
      end else begin
         snap_valid_in = snap_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         lead_ff       <= '0;
         main_ff       <= '0;
         second_ff     <= '0;
         extra_ff      <= '0;
         crc_ff        <= upc_pkg::CRC_INIT;
         footer_ff     <= '0;
         snap_valid_ff <= 1'b0;
      end else begin
         snap_valid_ff <= snap_valid_in;
         if (accept) begin
            if (final_byte) begin
               count_ff  <= '0;
               lead_ff   <= '0;
               main_ff   <= '0;
               second_ff <= '0;
               extra_ff  <= '0;
               crc_ff    <= upc_pkg::CRC_INIT;
               footer_ff <= '0;
            end else begin
               count_ff  <= count_in;
               lead_ff   <= lead_in;
               main_ff   <= main_in;
               second_ff <= second_in;
               extra_ff  <= extra_in;
               crc_ff    <= crc_in;
               footer_ff <= footer_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && final_byte) begin
         snap_ff <= snap_in;
      end
   end

`ifndef SYNTHESIS
   a_clear_after_final: assert property (@(posedge clock) disable iff (reset)
      accept && final_byte |=> count_ff == '0 && crc_ff == upc_pkg::CRC_INIT && snap_valid_ff)
      else $error("frame state not cleared after final byte");
   a_count_advance: assert property (@(posedge clock) disable iff (reset)
      accept && !final_byte && count_ff != upc_pkg::COUNT_MAX
      |=> count_ff == $past(count_ff) + 32'd1)
      else $error("byte counter did not advance");
   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(count_ff) && $stable(crc_ff) && $stable(footer_ff))
      else $error("frame state moved without a transaction");
`endif

endmodule

// ===== rtl/upc_verdict.sv =====
// Verdict stage: length, CRC and limit checks on a file snapshot, into the result register.
// Depends on upc_pkg; fed by upc_frame, drives the response channel payload.
`timescale 1ns / 1ps

module upc_verdict (
   input  logic              clock,
   input  logic              reset,
   input  logic              snap_valid,
   output logic              snap_ready,
   input  upc_pkg::snap_type snap,
   input  logic [23:0]       main_limit,
   input  logic [23:0]       second_limit,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [2:0]        status,
   output logic              is_package,
   output logic [1:0]        image_count,
   output logic [23:0]       main_length,
   output logic [23:0]       second_length
);

   logic                 valid_ff, valid_in;
   upc_pkg::status_type  status_ff, status_in;
   logic                 pkg_ff, pkg_in;
   logic [1:0]           count_ff, count_in;
   logic [23:0]          mlen_ff, mlen_in;
   logic [23:0]          slen_ff, slen_in;
   logic                 take;
   logic                 saturated;
   logic [33:0]          expected_total;

   assign snap_ready    = !valid_ff || out_ready;
   assign take          = snap_valid && snap_ready;
   assign out_valid     = valid_ff;
   assign status        = status_ff;
   assign is_package    = pkg_ff;
   assign image_count   = count_ff;
   assign main_length   = mlen_ff;
   assign second_length = slen_ff;

   always_comb begin
      saturated      = snap.byte_count == upc_pkg::COUNT_MAX;
      expected_total = upc_pkg::BODY_PLUS_FOOTER + {2'b00, snap.main_size}
                       + {2'b00, snap.second_size} + {2'b00, snap.extra_size};
      pkg_in    = snap.byte_count >= upc_pkg::MIN_PACKAGE
                  && snap.leading_word == upc_pkg::TAG_WORD;
      status_in = upc_pkg::STATUS_OK;
      count_in  = 2'd0;
      mlen_in   = '0;
      slen_in   = '0;
      if (pkg_in) begin
         if (saturated || expected_total != {2'b00, snap.byte_count}) begin
            status_in = upc_pkg::STATUS_SIZE_MISMATCH;
         end else if (~snap.running_crc != snap.footer_word) begin
            status_in = upc_pkg::STATUS_CRC_MISMATCH;
         end else if (snap.main_size == '0 || snap.main_size > {8'd0, main_limit}
                      || snap.second_size > {8'd0, second_limit}) begin
            status_in = upc_pkg::STATUS_OUT_OF_RANGE;
         end else begin
            mlen_in  = snap.main_size[23:0];
            slen_in  = snap.second_size[23:0];
            count_in = (snap.second_size != '0) ? 2'd2 : 2'd1;
         end
      end else begin
         if (saturated || snap.byte_count > {8'd0, main_limit}) begin
            status_in = upc_pkg::STATUS_RAW_TOO_LARGE;
         end else begin
            mlen_in  = snap.byte_count[23:0];
            count_in = 2'd1;
         end
      end

      if (take) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         status_ff <= status_in;
         pkg_ff    <= pkg_in;
         count_ff  <= count_in;
         mlen_ff   <= mlen_in;
         slen_ff   <= slen_in;
      end
   end

`ifndef SYNTHESIS
   a_error_clears_lengths: assert property (@(posedge clock) disable iff (reset)
      valid_ff && status_ff != upc_pkg::STATUS_OK
      |-> count_ff == 2'd0 && mlen_ff == '0 && slen_ff == '0)
      else $error("lengths reported with an error verdict");
   a_raw_consistent: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !pkg_ff |-> slen_ff == '0
      && (status_ff == upc_pkg::STATUS_OK || status_ff == upc_pkg::STATUS_RAW_TOO_LARGE))
      else $error("raw file verdict inconsistent");
   a_take_loads: assert property (@(posedge clock) disable iff (reset)
      take |=> valid_ff)
      else $error("snapshot taken without a result");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for update_package_checker_top: streams firmware files byte by byte
// and compares each verdict with a local predictor of the package checker (CRC-32, limits).
// Depends on upc_pkg, the channel interfaces in upc_if and the RTL top level.
`timescale 1ns / 1ps

module testbench;

   localparam int          HOLD_CYCLES  = 300;
   localparam int          DRAIN_CYCLES = 8;
   localparam int          CYCLE_LIMIT  = 200000;
   localparam logic [33:0] HEADER_LEN   = 34'd24;
   localparam logic [33:0] FOOTER_LEN   = 34'd4;
   localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;

   typedef struct packed {
      upc_pkg::status_type status;
      logic                is_package;
      logic [1:0]          image_count;
      logic [23:0]         main_length;
      logic [23:0]         second_length;
   } verdict_type;

   typedef struct packed {
      logic [7:0]  data;
      logic        last;
      logic        typed;
      verdict_type verdict;
   } stim_row_type;

   typedef enum int {
      KIND_RAW,
      KIND_PKG_GOOD,
      KIND_PKG_BAD_CRC,
      KIND_PKG_BAD_LENGTH,
      KIND_PKG_ZERO_MAIN,
      KIND_PKG_BIG_MAIN,
      KIND_PKG_BIG_SECOND
   } file_kind_type;

   localparam verdict_type NO_VERDICT = '{upc_pkg::STATUS_OK, 1'b0, 2'd0, 24'd0, 24'd0};

   // raw files at reset limits, short "BOOT" prefixes, extreme byte values
   localparam stim_row_type DIRECTED_ROWS [17] = '{
      '{8'h00, 1'b1, 1'b1, '{upc_pkg::STATUS_OK, 1'b0, 2'd1, 24'd1, 24'd0}},
      '{8'hFF, 1'b1, 1'b1, '{upc_pkg::STATUS_OK, 1'b0, 2'd1, 24'd1, 24'd0}},
      '{8'h42, 1'b0, 1'b0, NO_VERDICT},
      '{8'h4F, 1'b0, 1'b0, NO_VERDICT},
      '{8'h4F, 1'b0, 1'b0, NO_VERDICT},
      '{8'h54, 1'b1, 1'b1, '{upc_pkg::STATUS_OK, 1'b0, 2'd1, 24'd4, 24'd0}},
      '{8'h80, 1'b0, 1'b0, NO_VERDICT},
      '{8'h01, 1'b0, 1'b0, NO_VERDICT},
      '{8'h7F, 1'b1, 1'b1, '{upc_pkg::STATUS_OK, 1'b0, 2'd1, 24'd3, 24'd0}},
      '{8'h42, 1'b0, 1'b0, NO_VERDICT},
      '{8'h4F, 1'b0, 1'b0, NO_VERDICT},
      '{8'h4F, 1'b0, 1'b0, NO_VERDICT},
      '{8'h54, 1'b0, 1'b0, NO_VERDICT},
      '{8'hFF, 1'b0, 1'b0, NO_VERDICT},
      '{8'h00, 1'b0, 1'b0, NO_VERDICT},
      '{8'hA5, 1'b0, 1'b0, NO_VERDICT},
      '{8'h5A, 1'b1, 1'b0, NO_VERDICT}
   };

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [0:0]  csr_index;
   logic [23:0] csr_write_data;

   upc_req_if req_if();
   upc_rsp_if rsp_if();

   update_package_checker_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_if),
      .rsp_if           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // predictor state
   logic [23:0] lim_main;
   logic [23:0] lim_second;
   logic [31:0] seen_count;
   logic [31:0] tag_word;
   logic [31:0] hdr_main;
   logic [31:0] hdr_second;
   logic [31:0] hdr_extra;
   logic [31:0] crc_acc;
   logic [31:0] tail_word;

   verdict_type expected_verdicts[$];
   verdict_type oldest_verdict;
   int          errors = 0;
   int          items_sent = 0;
   int          cycle_count = 0;
   bit          no_idle = 1'b0;
   bit          hold_request = 1'b0;

   function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] value);
      logic [31:0] c;
      c = crc ^ {24'd0, value};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   function automatic void clear_file_state();
      seen_count = '0;
      tag_word   = '0;
      hdr_main   = '0;
      hdr_second = '0;
      hdr_extra  = '0;
      crc_acc    = upc_pkg::CRC_INIT;
      tail_word  = '0;
   endfunction

   function automatic void predict_byte(input logic [7:0] value, input logic last,
                                        output logic produced, output verdict_type v);
      logic [31:0] idx;
      logic [4:0]  sh;
      logic [31:0] n;
      logic [33:0] body;
      logic        saturated;
      idx = seen_count;
      sh = {idx[1:0], 3'b000};
      produced = 1'b0;
      v = NO_VERDICT;
      if (idx < 4) begin
         tag_word |= {24'd0, value} << sh;
      end else if (idx < 8) begin
         hdr_main |= {24'd0, value} << sh;
      end else if (idx < 12) begin
         hdr_second |= {24'd0, value} << sh;
      end else if (idx < 16) begin
         hdr_extra |= {24'd0, value} << sh;
      end
      // the last four bytes wait in the tail before entering the CRC
      if (idx >= 4) begin
         crc_acc = crc_step(crc_acc, tail_word[7:0]);
      end
      tail_word = {value, tail_word[31:8]};
      if (seen_count != upc_pkg::COUNT_MAX) begin
         seen_count++;
      end
      if (last) begin
         produced = 1'b1;
         n = seen_count;
         saturated = (n == upc_pkg::COUNT_MAX);
         if (n >= upc_pkg::MIN_PACKAGE && tag_word == upc_pkg::TAG_WORD) begin
            body = HEADER_LEN + {2'b00, hdr_main} + {2'b00, hdr_second} + {2'b00, hdr_extra};
            v.is_package = 1'b1;
            if (saturated || body + FOOTER_LEN != {2'b00, n}) begin
               v.status = upc_pkg::STATUS_SIZE_MISMATCH;
            end else if (~crc_acc != tail_word) begin
               v.status = upc_pkg::STATUS_CRC_MISMATCH;
            end else if (hdr_main == 0 || hdr_main > {8'd0, lim_main}
                         || hdr_second > {8'd0, lim_second}) begin
               v.status = upc_pkg::STATUS_OUT_OF_RANGE;
            end else begin
               v.main_length = hdr_main[23:0];
               v.second_length = hdr_second[23:0];
               v.image_count = (hdr_second != 0) ? 2'd2 : 2'd1;
            end
         end else if (saturated || n > {8'd0, lim_main}) begin
            v.status = upc_pkg::STATUS_RAW_TOO_LARGE;
         end else begin
            v.main_length = n[23:0];
            v.image_count = 2'd1;
         end
         clear_file_state();
      end
   endfunction

   function automatic int cap(input int a, input int b);
      return (a < b) ? a : b;
   endfunction

   function automatic int pick_size(input int lo, input int hi);
      return (hi < lo) ? lo : int'($urandom_range(lo, hi));
   endfunction

   function automatic file_kind_type pick_kind();
      case ($urandom_range(0, 9))
         0, 1:    return KIND_RAW;
         6:       return KIND_PKG_BAD_CRC;
         7:       return KIND_PKG_BAD_LENGTH;
         8:       return KIND_PKG_ZERO_MAIN;
         9:       return ($urandom_range(0, 1) == 0) ? KIND_PKG_BIG_MAIN : KIND_PKG_BIG_SECOND;
         default: return KIND_PKG_GOOD;
      endcase
   endfunction

   task automatic compare_field(input string field, input logic [23:0] want,
                                input logic [23:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         errors++;
      end
   endtask

   task automatic send_byte(input logic [7:0] value, input logic last, input logic typed,
                            input verdict_type typed_verdict);
      int          gap;
      logic        produced;
      verdict_type predicted;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data_byte <= value;
      req_if.final_byte <= last;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
      predict_byte(value, last, produced, predicted);
      if (produced) begin
         expected_verdicts = {expected_verdicts, typed ? typed_verdict : predicted};
      end
   endtask

   task automatic send_file(input file_kind_type kind);
      logic [7:0]  file_data[$];
      logic [31:0] crc;
      int          main_n;
      int          second_n;
      int          extra_n;
      int          len;
      int          pos;
      no_idle = ($urandom_range(0, 3) == 0);
      if (kind == KIND_RAW) begin
         len = $urandom_range(1, 48);
         if (len >= 4 && $urandom_range(0, 2) == 0) begin
            for (int k = 0; k < 4; k++) file_data = {file_data, upc_pkg::TAG_WORD[8*k +: 8]};
         end
         while (file_data.size() < len) file_data = {file_data, 8'($urandom_range(0, 255))};
      end else begin
         if (kind == KIND_PKG_ZERO_MAIN) begin
            main_n = 0;
         end else if (kind == KIND_PKG_BIG_MAIN && lim_main <= 40) begin
            main_n = int'(lim_main) + $urandom_range(1, 6);
         end else if (lim_main >= 1 && lim_main <= 24 && $urandom_range(0, 3) == 0) begin
            main_n = int'(lim_main);
         end else begin
            main_n = pick_size(1, cap(int'(lim_main), 24));
         end
         if (kind == KIND_PKG_BIG_SECOND && lim_second <= 16) begin
            second_n = int'(lim_second) + $urandom_range(1, 4);
         end else if ($urandom_range(0, 2) == 0) begin
            second_n = 0;
         end else begin
            second_n = pick_size(0, cap(int'(lim_second), 16));
         end
         extra_n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
         for (int k = 0; k < 4; k++) file_data = {file_data, upc_pkg::TAG_WORD[8*k +: 8]};
         for (int k = 0; k < 4; k++) file_data = {file_data, 8'(main_n >> (8*k))};
         for (int k = 0; k < 4; k++) file_data = {file_data, 8'(second_n >> (8*k))};
         for (int k = 0; k < 4; k++) file_data = {file_data, 8'(extra_n >> (8*k))};
         repeat (8 + main_n + second_n + extra_n) begin
            file_data = {file_data, 8'($urandom_range(0, 255))};
         end
         crc = upc_pkg::CRC_INIT;
         foreach (file_data[i]) crc = crc_step(crc, file_data[i]);
         crc = ~crc;
         for (int k = 0; k < 4; k++) file_data = {file_data, crc[8*k +: 8]};
         if (kind == KIND_PKG_BAD_CRC) begin
            pos = $urandom_range(file_data.size() - 4, file_data.size() - 1);
            file_data[pos] ^= 8'h01 << $urandom_range(0, 7);
         end else if (kind == KIND_PKG_BAD_LENGTH) begin
            if ($urandom_range(0, 1) == 0) begin
               repeat ($urandom_range(1, 3)) file_data = {file_data, 8'($urandom_range(0, 255))};
            end else begin
               repeat ($urandom_range(1, 3)) void'(file_data.pop_back());
            end
         end
      end
      foreach (file_data[i]) begin
         send_byte(file_data[i], i == file_data.size() - 1, 1'b0, NO_VERDICT);
      end
   endtask

   task automatic send_random_until(input int target);
      while (items_sent < target) send_file(pick_kind());
   endtask

   // drop valid, drain every pending verdict, then let the pipeline empty
   task automatic settle();
      req_if.valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limits(input logic [23:0] main_lim, input logic [23:0] second_lim);
      csr_write_enable <= 1'b1;
      csr_index <= upc_pkg::CSR_MAIN_LIMIT;
      csr_write_data <= main_lim;
      @(posedge clock);
      lim_main = main_lim;
      csr_index <= upc_pkg::CSR_SECOND_LIMIT;
      csr_write_data <= second_lim;
      @(posedge clock);
      lim_second = second_lim;
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_verdicts.size() == 0) begin
            $display("%0t: unexpected verdict, status %0d main_length %0d", $time,
                     rsp_if.status, rsp_if.main_length);
            errors++;
         end else begin
            oldest_verdict = expected_verdicts.pop_front();
            compare_field("status", 24'(oldest_verdict.status), 24'(rsp_if.status));
            compare_field("is_package", 24'(oldest_verdict.is_package),
                          24'(rsp_if.is_package));
            compare_field("image_count", 24'(oldest_verdict.image_count),
                          24'(rsp_if.image_count));
            compare_field("main_length", oldest_verdict.main_length, rsp_if.main_length);
            compare_field("second_length", oldest_verdict.second_length, rsp_if.second_length);
         end
      end
   end

   // response side: random stalls, plus one long hold-off on request
   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_request) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end else begin
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
               rsp_if.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge clock); while (!rsp_if.valid && !hold_request);
         end
      end
   end

   initial begin
      file_kind_type kind_iter;
      req_if.valid <= 1'b0;
      req_if.data_byte <= 8'h00;
      req_if.final_byte <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index <= upc_pkg::CSR_MAIN_LIMIT;
      csr_write_data <= 24'd0;
      reset <= 1'b1;
      lim_main = upc_pkg::MAIN_LIMIT_RESET;
      lim_second = upc_pkg::SECOND_LIMIT_RESET;
      clear_file_state();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_ROWS[r]) begin
         send_byte(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].last, DIRECTED_ROWS[r].typed,
                   DIRECTED_ROWS[r].verdict);
      end
      send_random_until(400);
      settle();

      // small limits: every package verdict reachable, then fill the block
      write_limits(24'd24, 24'd8);
      for (int k = 0; k < kind_iter.num(); k++) send_file(file_kind_type'(k));
      hold_request = 1'b1;
      no_idle = 1'b1;
      repeat (60) send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, NO_VERDICT);
      send_random_until(850);
      settle();

      write_limits(24'd0, 24'd0);
      send_random_until(1050);
      settle();

      write_limits(24'hFF_FFFF, 24'hFF_FFFF);
      send_random_until(1400);
      settle();

      write_limits(24'($urandom_range(12, 40)), 24'($urandom_range(0, 10)));
      send_random_until(1650);
      settle();

      if (errors == 0 && expected_verdicts.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/upc_pkg.sv
rtl/upc_if.sv
rtl/upc_frame.sv
rtl/upc_verdict.sv
rtl/update_package_checker_top.sv
tb/testbench.sv
